// ===== rtl/pfs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the phase-field step block.
`default_nettype none
package pfs_pkg;

   localparam int GRID_X_DEFAULT = 64;
   localparam int GRID_Y_DEFAULT = 64;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_GRADIENT    = 3'd0;
   localparam logic [2:0] REG_MOBILITY_DT = 3'd1;
   localparam logic [2:0] REG_TIME_STEP   = 3'd2;
   localparam logic [2:0] REG_LATENT      = 3'd3;
   localparam logic [2:0] REG_MELT        = 3'd4;
   localparam logic [2:0] REG_INV_MELT    = 3'd5;
   localparam logic [2:0] REG_CONDUCT     = 3'd6;

   localparam logic [30:0] RST_GRADIENT    = 31'd781818266;
   localparam logic [30:0] RST_MOBILITY_DT = 31'd33554;
   localparam logic [30:0] RST_TIME_STEP   = 31'd33554;
   localparam logic [31:0] RST_LATENT      = 32'd16777216;
   localparam logic [31:0] RST_MELT        = 32'd16777216;
   localparam logic [31:0] RST_INV_MELT    = 32'd16777216;
   localparam logic [30:0] RST_CONDUCT     = 31'd16777216;

   // Sub-steps of one interior cell update.
   localparam logic [3:0] SUB_FETCH_DN   = 4'd0;
   localparam logic [3:0] SUB_FETCH_C    = 4'd1;
   localparam logic [3:0] SUB_FETCH_UP   = 4'd2;
   localparam logic [3:0] SUB_FETCH_PREV = 4'd3;
   localparam logic [3:0] SUB_CAP_PREV   = 4'd4;
   localparam logic [3:0] SUB_WRITE      = 4'd15;

   localparam logic signed [39:0] Q_ONE = 40'sd16777216;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_STEP  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      WR_INPUT = 2'd0,
      WR_COPY  = 2'd1,
      WR_CELL  = 2'd2
   } wr_src_type;

   typedef enum logic [1:0] {
      RSP_ZERO = 2'd0,
      RSP_READ = 2'd1,
      RSP_STEP = 2'd2
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD0,
      ST_LOADC,
      ST_CELL,
      ST_ECOL_RD,
      ST_ECOL_WR,
      ST_EROW_RD,
      ST_EROW_WR,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic signed [31:0] phase;
      logic signed [31:0] temp;
   } cell_type;

   typedef struct packed {
      logic signed [31:0] kappa;
      logic signed [31:0] mob_dt;
      logic signed [31:0] dt;
      logic signed [31:0] latent;
      logic signed [31:0] melt;
      logic signed [31:0] inv_melt;
      logic signed [31:0] cond;
   } cfg_type;

   typedef struct packed {
      logic         grid_rd;
      logic         grid_wr;
      wr_src_type   wr_src;
      logic         fill;
      logic         cb_rd;
      logic         cap_right;
      logic         cap_dn;
      logic         cap_c;
      logic         cap_up;
      logic         cap_prev;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
      return 40'(v);
   endfunction

   function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   // Q8.24 product, rounded half up and saturated.
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] r;
      p = a * b;
      r = (p + 64'sd8388608) >>> 24;
      return sat40(r[39:0]);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pfs_csr.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none
module pfs_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [pfs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [pfs_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [pfs_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready,
   output pfs_pkg::cfg_type                cfg
);
   logic [30:0] gradient_ff, gradient_in;
   logic [30:0] mobility_ff, mobility_in;
   logic [30:0] tstep_ff, tstep_in;
   logic [31:0] latent_ff, latent_in;
   logic [31:0] melt_ff, melt_in;
   logic [31:0] inv_melt_ff, inv_melt_in;
   logic [30:0] conduct_ff, conduct_in;
   logic [2:0]  index;
   logic        wr_en;

   assign index      = csr_paddr[pfs_pkg::CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      gradient_in = gradient_ff;
      mobility_in = mobility_ff;
      tstep_in    = tstep_ff;
      latent_in   = latent_ff;
      melt_in     = melt_ff;
      inv_melt_in = inv_melt_ff;
      conduct_in  = conduct_ff;
      if (wr_en) begin
         case (index)
            pfs_pkg::REG_GRADIENT:    gradient_in = csr_pwdata[30:0];
            pfs_pkg::REG_MOBILITY_DT: mobility_in = csr_pwdata[30:0];
            pfs_pkg::REG_TIME_STEP:   tstep_in    = csr_pwdata[30:0];
            pfs_pkg::REG_LATENT:      latent_in   = csr_pwdata;
            pfs_pkg::REG_MELT:        melt_in     = csr_pwdata;
            pfs_pkg::REG_INV_MELT:    inv_melt_in = csr_pwdata;
            pfs_pkg::REG_CONDUCT:     conduct_in  = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gradient_ff <= pfs_pkg::RST_GRADIENT;
         mobility_ff <= pfs_pkg::RST_MOBILITY_DT;
         tstep_ff    <= pfs_pkg::RST_TIME_STEP;
         latent_ff   <= pfs_pkg::RST_LATENT;
         melt_ff     <= pfs_pkg::RST_MELT;
         inv_melt_ff <= pfs_pkg::RST_INV_MELT;
         conduct_ff  <= pfs_pkg::RST_CONDUCT;
      end else begin
         gradient_ff <= gradient_in;
         mobility_ff <= mobility_in;
         tstep_ff    <= tstep_in;
         latent_ff   <= latent_in;
         melt_ff     <= melt_in;
         inv_melt_ff <= inv_melt_in;
         conduct_ff  <= conduct_in;
      end
   end

   always_comb begin
      case (index)
         pfs_pkg::REG_GRADIENT:    csr_prdata = {1'b0, gradient_ff};
         pfs_pkg::REG_MOBILITY_DT: csr_prdata = {1'b0, mobility_ff};
         pfs_pkg::REG_TIME_STEP:   csr_prdata = {1'b0, tstep_ff};
         pfs_pkg::REG_LATENT:      csr_prdata = latent_ff;
         pfs_pkg::REG_MELT:        csr_prdata = melt_ff;
         pfs_pkg::REG_INV_MELT:    csr_prdata = inv_melt_ff;
         pfs_pkg::REG_CONDUCT:     csr_prdata = {1'b0, conduct_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.kappa    = {1'b0, gradient_ff};
   assign cfg.mob_dt   = {1'b0, mobility_ff};
   assign cfg.dt       = {1'b0, tstep_ff};
   assign cfg.latent   = latent_ff;
   assign cfg.melt     = melt_ff;
   assign cfg.inv_melt = inv_melt_ff;
   assign cfg.cond     = {1'b0, conduct_ff};
endmodule
`default_nettype wire

// ===== rtl/pfs_ctrl.sv =====
// Sequencer for transactions and the grid sweep of a time step.
`default_nettype none
module pfs_ctrl #(
   parameter int GRID_X = pfs_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = pfs_pkg::GRID_Y_DEFAULT,
   localparam int XW = $clog2(GRID_X),
   localparam int YW = $clog2(GRID_Y),
   localparam int AW = $clog2(GRID_X * GRID_Y)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_func,
   input  wire logic [5:0]   req_cell_x,
   input  wire logic [5:0]   req_cell_y,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output pfs_pkg::cmd_type  cmd,
   output logic [AW-1:0]     grid_addr,
   output logic [YW:0]       cb_addr,
   output logic [YW:0]       cb_wr_addr
);
   localparam logic [XW-1:0] XMAX = XW'(GRID_X - 1);
   localparam logic [YW-1:0] YMAX = YW'(GRID_Y - 1);

   pfs_pkg::ctrl_state_type state_ff, state_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [3:0]    sub_ff, sub_in;
   logic          side_ff, side_in;
   logic          bank_ff, bank_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rd_inside_ff, rd_inside_in;

   logic          accept;
   logic          in_grid;
   logic          use_req;
   logic [XW-1:0] ax;
   logic [YW-1:0] ay;
   logic [AW-1:0] req_addr;

   assign req_stall = (state_ff != pfs_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign in_grid   = (32'(req_cell_x) < GRID_X) && (32'(req_cell_y) < GRID_Y);
   assign req_addr  = AW'(req_cell_x) * AW'(GRID_Y) + AW'(req_cell_y);
   assign rsp_valid = rsp_valid_ff;
   assign grid_addr = use_req ? req_addr : AW'(ax) * AW'(GRID_Y) + AW'(ay);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sub_in       = sub_ff;
      side_in      = side_ff;
      bank_in      = bank_ff;
      rd_inside_in = rd_inside_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.rsp_load;
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (accept) begin
               case (pfs_pkg::func_type'(req_func))
                  pfs_pkg::FUNC_READ: begin
                     state_in     = pfs_pkg::ST_READ;
                     rd_inside_in = in_grid;
                  end
                  pfs_pkg::FUNC_STEP: begin
                     state_in = pfs_pkg::ST_LOAD0;
                     x_in     = '0;
                     y_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         pfs_pkg::ST_READ: state_in = pfs_pkg::ST_IDLE;
         pfs_pkg::ST_LOAD0: begin
            if (y_ff == YMAX) begin
               y_in     = '0;
               x_in     = XW'(1);
               state_in = pfs_pkg::ST_LOADC;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         pfs_pkg::ST_LOADC: begin
            if (y_ff == YMAX) begin
               y_in     = YW'(1);
               sub_in   = '0;
               state_in = pfs_pkg::ST_CELL;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         pfs_pkg::ST_CELL: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == pfs_pkg::SUB_WRITE) begin
               if (y_ff == YMAX - 1'b1) begin
                  // The current column becomes the previous one.
                  bank_in = !bank_ff;
                  if (x_ff == XMAX - 1'b1) begin
                     y_in     = YW'(1);
                     side_in  = 1'b0;
                     state_in = pfs_pkg::ST_ECOL_RD;
                  end else begin
                     x_in     = x_ff + 1'b1;
                     y_in     = '0;
                     state_in = pfs_pkg::ST_LOADC;
                  end
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end
         pfs_pkg::ST_ECOL_RD: state_in = pfs_pkg::ST_ECOL_WR;
         pfs_pkg::ST_ECOL_WR: begin
            side_in  = !side_ff;
            state_in = pfs_pkg::ST_ECOL_RD;
            if (side_ff) begin
               if (y_ff == YMAX - 1'b1) begin
                  x_in     = '0;
                  state_in = pfs_pkg::ST_EROW_RD;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end
         pfs_pkg::ST_EROW_RD: state_in = pfs_pkg::ST_EROW_WR;
         pfs_pkg::ST_EROW_WR: begin
            side_in  = !side_ff;
            state_in = pfs_pkg::ST_EROW_RD;
            if (side_ff) begin
               if (x_ff == XMAX) begin
                  state_in = pfs_pkg::ST_DONE;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
         end
         pfs_pkg::ST_DONE: begin
            x_in     = '0;
            state_in = pfs_pkg::ST_IDLE;
         end
         default: state_in = pfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      use_req    = 1'b0;
      ax         = x_ff;
      ay         = y_ff;
      cb_addr    = {bank_ff, y_ff};
      cb_wr_addr = {bank_ff, y_ff};
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            use_req = 1'b1;
            if (accept) begin
               case (pfs_pkg::func_type'(req_func))
                  pfs_pkg::FUNC_WRITE: begin
                     cmd.grid_wr  = in_grid;
                     cmd.wr_src   = pfs_pkg::WR_INPUT;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = pfs_pkg::RSP_ZERO;
                  end
                  pfs_pkg::FUNC_READ: cmd.grid_rd = in_grid;
                  pfs_pkg::FUNC_NONE: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = pfs_pkg::RSP_ZERO;
                  end
                  default: ;
               endcase
            end
         end
         pfs_pkg::ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = rd_inside_ff ? pfs_pkg::RSP_READ : pfs_pkg::RSP_ZERO;
         end
         pfs_pkg::ST_LOAD0: begin
            cmd.grid_rd = 1'b1;
            cmd.fill    = 1'b1;
            cb_wr_addr  = {!bank_ff, y_ff};
         end
         pfs_pkg::ST_LOADC: begin
            cmd.grid_rd = 1'b1;
            cmd.fill    = 1'b1;
         end
         pfs_pkg::ST_CELL: begin
            case (sub_ff)
               pfs_pkg::SUB_FETCH_DN: begin
                  cmd.grid_rd = 1'b1;
                  ax          = x_ff + 1'b1;
                  cmd.cb_rd   = 1'b1;
                  cb_addr     = {bank_ff, y_ff - 1'b1};
               end
               pfs_pkg::SUB_FETCH_C: begin
                  cmd.cap_right = 1'b1;
                  cmd.cap_dn    = 1'b1;
                  cmd.cb_rd     = 1'b1;
               end
               pfs_pkg::SUB_FETCH_UP: begin
                  cmd.cap_c = 1'b1;
                  cmd.cb_rd = 1'b1;
                  cb_addr   = {bank_ff, y_ff + 1'b1};
               end
               pfs_pkg::SUB_FETCH_PREV: begin
                  cmd.cap_up = 1'b1;
                  cmd.cb_rd  = 1'b1;
                  cb_addr    = {!bank_ff, y_ff};
               end
               pfs_pkg::SUB_CAP_PREV: cmd.cap_prev = 1'b1;
               pfs_pkg::SUB_WRITE: begin
                  cmd.grid_wr = 1'b1;
                  cmd.wr_src  = pfs_pkg::WR_CELL;
               end
               default: ;
            endcase
         end
         pfs_pkg::ST_ECOL_RD: begin
            cmd.grid_rd = 1'b1;
            ax          = side_ff ? XMAX - 1'b1 : XW'(1);
         end
         pfs_pkg::ST_ECOL_WR: begin
            cmd.grid_wr = 1'b1;
            cmd.wr_src  = pfs_pkg::WR_COPY;
            ax          = side_ff ? XMAX : '0;
         end
         pfs_pkg::ST_EROW_RD: begin
            cmd.grid_rd = 1'b1;
            ay          = side_ff ? YMAX - 1'b1 : YW'(1);
         end
         pfs_pkg::ST_EROW_WR: begin
            cmd.grid_wr = 1'b1;
            cmd.wr_src  = pfs_pkg::WR_COPY;
            ay          = side_ff ? YMAX : '0;
         end
         pfs_pkg::ST_DONE: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = pfs_pkg::RSP_STEP;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         sub_ff       <= '0;
         side_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_inside_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         sub_ff       <= sub_in;
         side_ff      <= side_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_inside_ff <= rd_inside_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/pfs_datapath.sv =====
// Grid memory, column buffers, cell update arithmetic and result registers.
`default_nettype none
module pfs_datapath #(
   parameter int GRID_X = pfs_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = pfs_pkg::GRID_Y_DEFAULT,
   localparam int YW = $clog2(GRID_Y),
   localparam int AW = $clog2(GRID_X * GRID_Y)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfs_pkg::cmd_type  cmd,
   input  wire logic [AW-1:0]     grid_addr,
   input  wire logic [YW:0]       cb_addr,
   input  wire logic [YW:0]       cb_wr_addr,
   input  wire pfs_pkg::cfg_type  cfg,
   input  wire logic signed [31:0] req_phase_in,
   input  wire logic signed [31:0] req_temperature_in,
   output logic signed [31:0]     rsp_phase_out,
   output logic signed [31:0]     rsp_temperature_out,
   output logic                   rsp_step_done
);
   localparam int CELLS = GRID_X * GRID_Y;

   pfs_pkg::cell_type grid_mem [CELLS];
   pfs_pkg::cell_type cb_mem [2 ** (YW + 1)];
   pfs_pkg::cell_type grid_rdata_ff;
   pfs_pkg::cell_type cb_rdata_ff;
   pfs_pkg::cell_type wdata;

   logic        fill_valid_ff;
   logic [YW:0] fill_addr_ff;

   pfs_pkg::cell_type right_ff, dn_ff, c_ff, up_ff, prev_ff;

   logic signed [31:0] le_ff, le_in, lt_ff, lt_in, om_ff, om_in, tm_ff, tm_in;
   logic signed [31:0] one2e_ff, one2e_in;
   logic signed [31:0] w_ff, w_in, p1_ff, p1_in, g_ff, g_in, k_ff, k_in;
   logic signed [31:0] drive_ff, drive_in, w6_ff, w6_in, w18_ff, w18_in;
   logic signed [31:0] d0_ff, d0_in, lw_ff, lw_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, lw6_ff, lw6_in;
   logic signed [31:0] d_ff, d_in, de_ff, de_in, h2_ff, h2_in, enew_ff, enew_in;
   logic signed [31:0] ht_ff, ht_in, tq_ff, tq_in, tnew_ff, tnew_in;

   logic signed [31:0] rsp_phase_ff, rsp_temp_ff;
   logic               rsp_done_ff;

   always_comb begin
      case (cmd.wr_src)
         pfs_pkg::WR_INPUT: wdata = '{phase: req_phase_in, temp: req_temperature_in};
         pfs_pkg::WR_COPY:  wdata = grid_rdata_ff;
         pfs_pkg::WR_CELL:  wdata = '{phase: enew_ff, temp: tnew_ff};
         default:           wdata = grid_rdata_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.grid_wr) begin
         grid_mem[grid_addr] <= wdata;
      end
      if (cmd.grid_rd) begin
         grid_rdata_ff <= grid_mem[grid_addr];
      end
   end

   // Column fill writes land in the cycle after the grid read they copy.
   always_ff @(posedge clock) begin
      if (fill_valid_ff) begin
         cb_mem[fill_addr_ff] <= grid_rdata_ff;
      end
      if (cmd.cb_rd) begin
         cb_rdata_ff <= cb_mem[cb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_valid_ff <= 1'b0;
      end else begin
         fill_valid_ff <= cmd.fill;
      end
      fill_addr_ff <= cb_wr_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_right) right_ff <= grid_rdata_ff;
      if (cmd.cap_dn)    dn_ff    <= cb_rdata_ff;
      if (cmd.cap_c)     c_ff     <= cb_rdata_ff;
      if (cmd.cap_up)    up_ff    <= cb_rdata_ff;
      if (cmd.cap_prev)  prev_ff  <= cb_rdata_ff;
   end

   // The operands stay put through the update, so each stage settles in turn.
   always_comb begin
      le_in = pfs_pkg::sat40(pfs_pkg::ext40(right_ff.phase) + pfs_pkg::ext40(prev_ff.phase)
                 + pfs_pkg::ext40(up_ff.phase) + pfs_pkg::ext40(dn_ff.phase)
                 - (pfs_pkg::ext40(c_ff.phase) <<< 2));
      lt_in = pfs_pkg::sat40(pfs_pkg::ext40(right_ff.temp) + pfs_pkg::ext40(prev_ff.temp)
                 + pfs_pkg::ext40(up_ff.temp) + pfs_pkg::ext40(dn_ff.temp)
                 - (pfs_pkg::ext40(c_ff.temp) <<< 2));
      om_in    = pfs_pkg::sat40(pfs_pkg::Q_ONE - pfs_pkg::ext40(c_ff.phase));
      tm_in    = pfs_pkg::sat40(pfs_pkg::ext40(c_ff.temp) - pfs_pkg::ext40(cfg.melt));
      one2e_in = pfs_pkg::sat40(pfs_pkg::Q_ONE - (pfs_pkg::ext40(c_ff.phase) <<< 1));

      w_in  = pfs_pkg::qmul(c_ff.phase, om_ff);
      p1_in = pfs_pkg::qmul(tm_ff, cfg.inv_melt);
      g_in  = pfs_pkg::qmul(cfg.kappa, le_ff);
      k_in  = pfs_pkg::qmul(cfg.cond, lt_ff);

      drive_in = pfs_pkg::qmul(cfg.latent, p1_ff);
      w6_in    = pfs_pkg::sat40(pfs_pkg::ext40(w_ff) * 40'sd6);
      w18_in   = pfs_pkg::sat40(pfs_pkg::ext40(w_ff) * 40'sd18);
      d0_in    = pfs_pkg::sat40(pfs_pkg::ext40(g_ff) <<< 1);
      lw_in    = pfs_pkg::qmul(cfg.latent, w_ff);

      a_in   = pfs_pkg::qmul(drive_ff, w6_ff);
      b_in   = pfs_pkg::qmul(w18_ff, one2e_ff);
      lw6_in = pfs_pkg::sat40(pfs_pkg::ext40(lw_ff) * 40'sd6);

      d_in = pfs_pkg::sat40(pfs_pkg::ext40(pfs_pkg::sat40(pfs_pkg::ext40(d0_ff)
                - pfs_pkg::ext40(a_ff))) - pfs_pkg::ext40(b_ff));

      de_in = pfs_pkg::qmul(d_ff, cfg.mob_dt);

      h2_in   = pfs_pkg::qmul(lw6_ff, de_ff);
      enew_in = pfs_pkg::sat40(pfs_pkg::ext40(c_ff.phase) + pfs_pkg::ext40(de_ff));

      ht_in   = pfs_pkg::sat40(pfs_pkg::ext40(k_ff) + pfs_pkg::ext40(h2_ff));
      tq_in   = pfs_pkg::qmul(cfg.dt, ht_ff);
      tnew_in = pfs_pkg::sat40(pfs_pkg::ext40(c_ff.temp) + pfs_pkg::ext40(tq_ff));
   end

   always_ff @(posedge clock) begin
      le_ff    <= le_in;
      lt_ff    <= lt_in;
      om_ff    <= om_in;
      tm_ff    <= tm_in;
      one2e_ff <= one2e_in;
      w_ff     <= w_in;
      p1_ff    <= p1_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      drive_ff <= drive_in;
      w6_ff    <= w6_in;
      w18_ff   <= w18_in;
      d0_ff    <= d0_in;
      lw_ff    <= lw_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      lw6_ff   <= lw6_in;
      d_ff     <= d_in;
      de_ff    <= de_in;
      h2_ff    <= h2_in;
      enew_ff  <= enew_in;
      ht_ff    <= ht_in;
      tq_ff    <= tq_in;
      tnew_ff  <= tnew_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            pfs_pkg::RSP_READ: begin
               rsp_phase_ff <= grid_rdata_ff.phase;
               rsp_temp_ff  <= grid_rdata_ff.temp;
               rsp_done_ff  <= 1'b0;
            end
            pfs_pkg::RSP_STEP: begin
               rsp_phase_ff <= '0;
               rsp_temp_ff  <= '0;
               rsp_done_ff  <= 1'b1;
            end
            default: begin
               rsp_phase_ff <= '0;
               rsp_temp_ff  <= '0;
               rsp_done_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_phase_out       = rsp_phase_ff;
   assign rsp_temperature_out = rsp_temp_ff;
   assign rsp_step_done       = rsp_done_ff;
endmodule
`default_nettype wire

// ===== rtl/phase_field_solidification_step.sv =====
// A write or no-op transaction loads its result register on acceptance. A read first registers
// the grid word, holding off the next request, and loads the result in the READ state. A step
// loads the column buffers, runs the cell sequence on the single grid port, then copies edges.
// One transaction is in flight at a time; writes can follow every cycle while no result stalls.
// Reset is synchronous and active high; it clears control state and loads register
// defaults, while grid contents stay undefined until written.
`default_nettype none
module phase_field_solidification_step #(
   parameter int GRID_X = pfs_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = pfs_pkg::GRID_Y_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_func,
   input  wire logic [5:0]                 req_cell_x,
   input  wire logic [5:0]                 req_cell_y,
   input  wire logic signed [31:0]         req_phase_in,
   input  wire logic signed [31:0]         req_temperature_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [31:0]              rsp_phase_out,
   output logic signed [31:0]              rsp_temperature_out,
   output logic                            rsp_step_done,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [pfs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [pfs_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [pfs_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready
);
   localparam int YW = $clog2(GRID_Y);
   localparam int AW = $clog2(GRID_X * GRID_Y);

   pfs_pkg::cfg_type cfg;
   pfs_pkg::cmd_type cmd;
   logic [AW-1:0]    grid_addr;
   logic [YW:0]      cb_addr;
   logic [YW:0]      cb_wr_addr;

   pfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfs_ctrl #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .grid_addr  (grid_addr),
      .cb_addr    (cb_addr),
      .cb_wr_addr (cb_wr_addr)
   );

   pfs_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .grid_addr           (grid_addr),
      .cb_addr             (cb_addr),
      .cb_wr_addr          (cb_wr_addr),
      .cfg                 (cfg),
      .req_phase_in        (req_phase_in),
      .req_temperature_in  (req_temperature_in),
      .rsp_phase_out       (rsp_phase_out),
      .rsp_temperature_out (rsp_temperature_out),
      .rsp_step_done       (rsp_step_done)
   );

`ifndef SYNTHESIS
   // A step result never carries cell data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_done |-> rsp_phase_out == 0 && rsp_temperature_out == 0)
      else $error("step result carries cell data");

   // An accepted step keeps the input side stalled while the sweep runs.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == pfs_pkg::FUNC_STEP |=> req_stall)
      else $error("input taken during a step");

   // A read transaction always produces a non-step result once it has passed through the READ state.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == pfs_pkg::FUNC_READ
      |=> ##1 rsp_valid && !rsp_step_done)
      else $error("read result missing");
`endif
endmodule
`default_nettype wire
